// File: hdl/psmg_pkg.sv
package psmg_pkg;

    localparam int TABLE_ENTRIES_DEF = 16;

    localparam int SESSION_W = 64;
    localparam int STREAM_W  = 32;
    localparam int STAMP_W   = 64;
    localparam int VERDICT_W = 2;

    localparam logic [VERDICT_W-1:0] VERDICT_UPDATED = 2'd0;
    localparam logic [VERDICT_W-1:0] VERDICT_ADDED   = 2'd1;
    localparam logic [VERDICT_W-1:0] VERDICT_STALE   = 2'd2;
    localparam logic [VERDICT_W-1:0] VERDICT_FULL    = 2'd3;

    // Query token passed from cell to cell.
    typedef struct packed {
        logic                 done;
        logic [STREAM_W-1:0]  stream;
        logic [STAMP_W-1:0]   stamp;
        logic                 accepted;
        logic [VERDICT_W-1:0] verdict;
    } t_token;

endpackage

// File: hdl/psmg_in_if.sv
interface psmg_in_if;
    import psmg_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [SESSION_W-1:0] session_tag;
    logic [STREAM_W-1:0]  stream_tag;
    logic [STAMP_W-1:0]   stamp;

    modport source (output valid, output session_tag, output stream_tag, output stamp,
                    input ready);
    modport sink (input valid, input session_tag, input stream_tag, input stamp,
                  output ready);
endinterface

// File: hdl/psmg_res_if.sv
interface psmg_res_if;
    import psmg_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 accepted;
    logic [VERDICT_W-1:0] verdict;

    modport source (output valid, output accepted, output verdict, input ready);
    modport sink (input valid, input accepted, input verdict, output ready);
endinterface

// File: hdl/psmg_cell.sv
module psmg_cell #(
    parameter int IDX   = 0,
    parameter int CNT_W = 5
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_adv,
    input  logic [CNT_W-1:0] i_used,
    input  logic             i_vld,
    input  psmg_pkg::t_token i_tok,
    output logic             o_vld,
    output psmg_pkg::t_token o_tok
);
    import psmg_pkg::*;

    localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

    logic [STREAM_W-1:0] r_stream;
    logic [STAMP_W-1:0]  r_stamp;
    logic                r_vld;
    t_token              r_tok;
    t_token              n_tok;

    logic live;
    logic hit;
    logic slot;
    logic newer;

    assign live  = i_vld && !i_tok.done;
    assign hit   = live && (MY_IDX < i_used) && (r_stream == i_tok.stream);
    assign slot  = live && (MY_IDX == i_used);
    assign newer = i_tok.stamp > r_stamp;

    always_comb begin
        n_tok = i_tok;
        if (hit) begin
            n_tok.done     = 1'b1;
            n_tok.accepted = newer;
            n_tok.verdict  = newer ? VERDICT_UPDATED : VERDICT_STALE;
        end else if (slot) begin
            n_tok.done     = 1'b1;
            n_tok.accepted = 1'b1;
            n_tok.verdict  = VERDICT_ADDED;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_adv) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_tok <= n_tok;
            if (slot) begin
                r_stream <= i_tok.stream;
                r_stamp  <= i_tok.stamp;
            end else if (hit && newer) begin
                r_stamp <= i_tok.stamp;
            end
        end
    end

    assign o_vld = r_vld;
    assign o_tok = r_tok;
endmodule

// File: hdl/per_stream_monotonic_gate_top.sv
// Per-stream monotonic timestamp gate.
//
// i_in carries one beat per timestamp: session_tag, stream_tag, stamp.
// o_res returns one beat per input: accepted and verdict (updated, added,
// not newer, table full). Beats move on valid && ready.
//
// The stream table is a row of TABLE_ENTRIES cells, one entry each. An
// accepted beat is latched, then walks down the row one cell per cycle
// while the row is not stalled; the cell holding its stream judges and
// updates it, or the first free cell takes it. A beat that leaves the row
// unmatched with no free cell is "full". A beat passes the query register,
// the cells in order and the output register. One item in flight: i_in.ready
// is low from the input beat until the result lands in the output register.
// A new session id, or the first beat after reset, empties the table.
// Reset clears the session, the fill count and all valid flags.
// If the receiver stalls, the result holds in the output register; the next
// item may already enter and walks the row, then waits at the last cell.
module per_stream_monotonic_gate_top #(
    parameter int TABLE_ENTRIES = psmg_pkg::TABLE_ENTRIES_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    psmg_in_if.sink   i_in,
    psmg_res_if.source o_res
);
    import psmg_pkg::*;

    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    // session / fill state
    logic                 r_sess_vld;
    logic [SESSION_W-1:0] r_session;
    logic [CNT_W-1:0]     r_used;

    // latched query and control
    logic   r_q_vld;
    t_token r_q;
    logic   r_busy;

    // output register
    logic                 r_out_vld;
    logic                 r_out_acc;
    logic [VERDICT_W-1:0] r_out_verdict;

    // cell row links
    logic   w_vld [0:TABLE_ENTRIES];
    t_token w_tok [0:TABLE_ENTRIES];

    logic                 in_beat;
    logic                 adv;
    logic                 load;
    logic                 fin_acc;
    logic [VERDICT_W-1:0] fin_verdict;
    logic                 new_sess;

    assign in_beat  = i_in.valid && i_in.ready;
    assign i_in.ready = !r_busy;
    assign new_sess = !r_sess_vld || (i_in.session_tag != r_session);

    // row stalls only when a finished token cannot enter the output register
    assign adv  = !(w_vld[TABLE_ENTRIES] && r_out_vld && !o_res.ready);
    assign load = w_vld[TABLE_ENTRIES] && adv;

    // unmatched with no free cell: table full
    assign fin_acc     = w_tok[TABLE_ENTRIES].done && w_tok[TABLE_ENTRIES].accepted;
    assign fin_verdict = w_tok[TABLE_ENTRIES].done ? w_tok[TABLE_ENTRIES].verdict
                                                   : VERDICT_FULL;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sess_vld <= 1'b0;
            r_session  <= '0;
            r_used     <= '0;
            r_busy     <= 1'b0;
            r_q_vld    <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            if (in_beat) begin
                r_busy <= 1'b1;
                if (new_sess) begin
                    r_sess_vld <= 1'b1;
                    r_session  <= i_in.session_tag;
                    r_used     <= '0;
                end
            end
            if (adv) begin
                r_q_vld <= in_beat;
            end
            if (load) begin
                r_busy    <= 1'b0;
                r_out_vld <= 1'b1;
                if (fin_verdict == VERDICT_ADDED) begin
                    r_used <= r_used + CNT_W'(1);
                end
            end else if (o_res.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_q.done     <= 1'b0;
            r_q.stream   <= i_in.stream_tag;
            r_q.stamp    <= i_in.stamp;
            r_q.accepted <= 1'b0;
            r_q.verdict  <= VERDICT_FULL;
        end
        if (load) begin
            r_out_acc     <= fin_acc;
            r_out_verdict <= fin_verdict;
        end
    end

    assign w_vld[0] = r_q_vld;
    assign w_tok[0] = r_q;

    for (genvar k = 0; k < TABLE_ENTRIES; k++) begin : g_cell
        psmg_cell #(
            .IDX   (k),
            .CNT_W (CNT_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (adv),
            .i_used  (r_used),
            .i_vld   (w_vld[k]),
            .i_tok   (w_tok[k]),
            .o_vld   (w_vld[k+1]),
            .o_tok   (w_tok[k+1])
        );
    end

    assign o_res.valid    = r_out_vld;
    assign o_res.accepted = r_out_acc;
    assign o_res.verdict  = r_out_verdict;
endmodule

// File: hdl/psmg_chk.sv
module psmg_chk (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           i_in_ready,
    input logic                           i_res_valid,
    input logic                           i_res_ready,
    input logic                           i_res_accepted,
    input logic [psmg_pkg::VERDICT_W-1:0] i_res_verdict
);
    import psmg_pkg::*;

    // accept flag follows the verdict
    a_acc_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> (i_res_accepted ==
            ((i_res_verdict == VERDICT_UPDATED) || (i_res_verdict == VERDICT_ADDED))))
        else $error("accepted flag disagrees with verdict");

    // one item in flight
    a_busy_after_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input ready after beat");

    // ready returns only with a fresh result
    a_ready_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_in_ready) |-> i_res_valid)
        else $error("ready returned without result");

    // stalled result holds
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && !i_res_ready) |=>
            (i_res_valid && $stable(i_res_accepted) && $stable(i_res_verdict)))
        else $error("stalled result changed");
endmodule

bind per_stream_monotonic_gate_top psmg_chk u_psmg_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_res_valid    (o_res.valid),
    .i_res_ready    (o_res.ready),
    .i_res_accepted (o_res.accepted),
    .i_res_verdict  (o_res.verdict)
);

// File: bench/tb_top.sv
module tb_top;
    import psmg_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_ENTRIES   = TABLE_ENTRIES_DEF;
    // Cell row length plus one, used to size the final wait.
    localparam int WALK_CYCLES = N_ENTRIES + 1;
    localparam int N_RANDOM    = 1525;
    // One item in flight at a time, with gaps and stalls:
    // this limit is many times the slowest expected run.
    localparam int CYCLE_LIMIT = 600000;

    // Handshake pressure phases.
    localparam logic [1:0] PH_FREE       = 2'd0;
    localparam logic [1:0] PH_SEND_GAPS  = 2'd1;
    localparam logic [1:0] PH_RECV_STALL = 2'd2;
    localparam logic [1:0] PH_BOTH       = 2'd3;

    typedef struct packed {
        logic [SESSION_W-1:0] session;
        logic [STREAM_W-1:0]  stream;
        logic [STAMP_W-1:0]   stamp;
        logic [1:0]           phase;
        logic                 drain;   // hold this beat until all results are back
    } t_beat;

    typedef struct packed {
        logic                 accepted;
        logic [VERDICT_W-1:0] verdict;
    } t_verdict;

    logic i_clk;
    logic i_rst_n;

    psmg_in_if  in_if ();
    psmg_res_if res_if ();

    per_stream_monotonic_gate_top #(
        .TABLE_ENTRIES (N_ENTRIES)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_res   (res_if)
    );

    // Stimulus and expected verdicts.
    t_beat    pending[$];
    t_verdict verdict_q[$];
    t_beat    cur_beat;
    logic [1:0] drive_phase;

    int beats_sent;
    int results_seen;      // written with <= so the driver always sees the pre-edge count
    int mismatches;
    int cycles;
    int sessions_opened;
    int verdict_hits[4];

    // Shadow of the stream table.
    logic                 sess_live;
    logic [SESSION_W-1:0] sess_id;
    int                   used;
    logic [STREAM_W-1:0]  tab_stream[N_ENTRIES];
    logic [STAMP_W-1:0]   tab_stamp[N_ENTRIES];

    initial begin
        i_clk = 1'b0;
    end

    always #5 i_clk = ~i_clk;

    // Reset is asserted once at the start, then released for good.
    initial begin
        i_rst_n = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_top: timeout after %0d cycles, %0d of %0d results back",
                     cycles, results_seen, beats_sent);
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // Judges one beat against the shadow table and updates it.
    // A new session (or the very first beat) empties the table first.
    function automatic t_verdict judge_stamp(input t_beat b);
        t_verdict r;
        int       hit;
        if (!sess_live || b.session != sess_id) begin
            sess_live = 1'b1;
            sess_id   = b.session;
            used      = 0;
            sessions_opened++;
        end
        hit = -1;
        for (int k = 0; k < used; k++) begin
            if (hit < 0 && tab_stream[k] == b.stream)
                hit = k;
        end
        if (hit >= 0) begin
            // strictly newer only; equal counts as stale
            if (b.stamp <= tab_stamp[hit]) begin
                r.accepted = 1'b0;
                r.verdict  = VERDICT_STALE;
            end else begin
                tab_stamp[hit] = b.stamp;
                r.accepted     = 1'b1;
                r.verdict      = VERDICT_UPDATED;
            end
        end else if (used >= N_ENTRIES) begin
            // table full: unknown stream refused, table untouched
            r.accepted = 1'b0;
            r.verdict  = VERDICT_FULL;
        end else begin
            tab_stream[used] = b.stream;
            tab_stamp[used]  = b.stamp;
            used++;
            r.accepted = 1'b1;
            r.verdict  = VERDICT_ADDED;
        end
        return r;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic bit sender_gap(input logic [1:0] ph);
        if (ph == PH_SEND_GAPS)
            return $urandom_range(0, 99) < 56;
        if (ph == PH_BOTH)
            return $urandom_range(0, 99) < 34;
        return 1'b0;
    endfunction

    function automatic bit receiver_stall(input logic [1:0] ph);
        if (ph == PH_RECV_STALL)
            return $urandom_range(0, 99) < 56;
        if (ph == PH_BOTH)
            return $urandom_range(0, 99) < 34;
        return 1'b0;
    endfunction

    task automatic add_beat(input logic [63:0] session, input logic [31:0] stream,
                            input logic [63:0] stamp, input logic [1:0] ph,
                            input logic drain);
        t_beat b;
        b.session = session;
        b.stream  = stream;
        b.stamp   = stamp;
        b.phase   = ph;
        b.drain   = drain;
        pending.push_back(b);
    endtask

    task automatic report_miss(input string what, input int exp_val, input int act_val);
        if (mismatches < 10)
            $display("tb_top: mismatch on result %0d: %s expected %0d, got %0d",
                     results_seen, what, exp_val, act_val);
        mismatches++;
    endtask

    // Driver: offers queued beats, records each accepted beat in the predictor.
    // Every signal gets at most one <= per edge.
    always @(posedge i_clk) begin : drive_blk
        t_beat nxt;
        bit    launch;
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                verdict_q.push_back(judge_stamp(cur_beat));
                beats_sent++;
            end
            if (!in_if.valid || in_if.ready) begin
                launch = 1'b0;
                if (pending.size() > 0) begin
                    nxt = pending[0];
                    // drain hold: wait until every result is back
                    launch = !(nxt.drain && beats_sent != results_seen)
                             && !sender_gap(nxt.phase);
                end
                if (launch) begin
                    void'(pending.pop_front());
                    cur_beat               = nxt;
                    in_if.valid           <= 1'b1;
                    in_if.session_tag     <= nxt.session;
                    in_if.stream_tag      <= nxt.stream;
                    in_if.stamp           <= nxt.stamp;
                    drive_phase           <= nxt.phase;
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random back-pressure per phase.
    always @(posedge i_clk) begin
        if (!i_rst_n)
            res_if.ready <= 1'b0;
        else
            res_if.ready <= !receiver_stall(drive_phase);
    end

    // Monitor: each result beat is checked against the oldest expectation.
    always @(posedge i_clk) begin : check_blk
        t_verdict want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (verdict_q.size() == 0) begin
                if (mismatches < 10)
                    $display("tb_top: result beat with no expectation (accepted %0d verdict %0d)",
                             res_if.accepted, res_if.verdict);
                mismatches++;
            end else begin
                want = verdict_q.pop_front();
                if (res_if.accepted !== want.accepted)
                    report_miss("accepted", int'(want.accepted), int'(res_if.accepted));
                if (res_if.verdict !== want.verdict)
                    report_miss("verdict", int'(want.verdict), int'(res_if.verdict));
                verdict_hits[want.verdict]++;
            end
            results_seen <= results_seen + 1;
        end
    end

    // Stimulus build and end-of-run.
    initial begin : main_blk
        logic [63:0] sess;
        logic [63:0] st;
        logic [31:0] pool_id[24];
        logic [63:0] pool_stamp[24];
        int          made;
        int          run_len;
        int          pool_n;
        int          p;
        int          mode;
        logic [1:0]  ph;
        logic [1:0]  last_ph;
        logic        drain;

        in_if.valid       = 1'b0;
        in_if.session_tag = '0;
        in_if.stream_tag  = '0;
        in_if.stamp       = '0;
        res_if.ready      = 1'b0;
        drive_phase       = PH_FREE;
        beats_sent        = 0;
        results_seen      = 0;
        mismatches        = 0;
        cycles            = 0;
        sessions_opened   = 0;
        sess_live         = 1'b0;
        sess_id           = '0;
        used              = 0;
        for (int k = 0; k < 4; k++)
            verdict_hits[k] = 0;

        // ---- directed ----
        // first beat after reset, session 0 (same as the reset value of the id)
        add_beat(64'd0, 32'd0, 64'd0, PH_FREE, 1'b0);
        add_beat(64'd0, 32'd0, 64'd0, PH_FREE, 1'b0);          // equal stamp
        add_beat(64'd0, 32'd0, 64'd1, PH_FREE, 1'b0);          // newer
        add_beat(64'd0, 32'd0, 64'd0, PH_FREE, 1'b0);          // older
        add_beat(64'd0, '1, '1, PH_FREE, 1'b0);                // max stream, max stamp
        add_beat(64'd0, '1, '1, PH_FREE, 1'b0);                // max stamp again: stale
        for (int k = 1; k <= N_ENTRIES - 2; k++)
            add_beat(64'd0, k, 64'h100 + k, PH_FREE, 1'b0);  // fill the table
        add_beat(64'd0, 32'h1234_5678, 64'd7, PH_FREE, 1'b0);  // unknown stream, table full
        add_beat(64'd0, 32'd0, 64'd2, PH_FREE, 1'b0);          // known stream still updates
        add_beat('1, 32'h1234_5678, 64'd5, PH_FREE, 1'b0);     // session change: added
        add_beat('1, 32'd0, 64'd0, PH_FREE, 1'b0);             // fresh table: added
        add_beat(64'd0, 32'd0, 64'd0, PH_FREE, 1'b0);          // back to session 0

        // ---- random: well-formed sessions with per-stream rising stamps,
        //      some stale/equal stamps, big pools to hit the full table,
        //      and occasional stray beats that break the session ----
        made    = 0;
        last_ph = PH_FREE;
        while (made < N_RANDOM) begin
            mode = $urandom_range(0, 9);
            sess = (mode == 0) ? 64'd0 : (mode == 1) ? '1 : rand64();
            run_len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6)
                                                  : $urandom_range(10, 80);
            pool_n = $urandom_range(1, 24);
            for (int k = 0; k < pool_n; k++) begin
                pool_id[k]    = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom;
                pool_stamp[k] = ($urandom_range(0, 7) == 0) ? 64'd0
                                                            : rand64() >> $urandom_range(0, 40);
            end
            for (int j = 0; j < run_len && made < N_RANDOM; j++) begin
                ph      = 2'(made * 4 / N_RANDOM);
                drain   = (ph != last_ph) || ($urandom_range(0, 199) == 0);
                last_ph = ph;
                p       = $urandom_range(0, pool_n - 1);
                mode    = $urandom_range(0, 99);
                if (mode < 70) begin
                    pool_stamp[p] = pool_stamp[p] + $urandom_range(1, 1000);
                    st = pool_stamp[p];
                end else if (mode < 79) begin
                    st = pool_stamp[p];                         // equal
                end else if (mode < 88) begin
                    st = pool_stamp[p] - $urandom_range(1, 50); // older
                end else if (mode < 97) begin
                    pool_stamp[p] = rand64();
                    st = pool_stamp[p];
                end else begin
                    // stray beat from another session
                    add_beat(rand64(), $urandom, rand64(), ph, drain);
                    made++;
                    continue;
                end
                add_beat(sess, pool_id[p], st, ph, drain);
                made++;
            end
        end

        // ---- wait for everything to drain ----
        while (!i_rst_n || pending.size() > 0 || in_if.valid)
            @(posedge i_clk);
        while (results_seen != beats_sent)
            @(posedge i_clk);
        // any late extra result beat gets flagged by the monitor here
        repeat (2 * WALK_CYCLES) @(posedge i_clk);

        $display("tb_top: %0d stamps judged over %0d sessions and four handshake phases",
                 beats_sent, sessions_opened);
        $display("tb_top: verdicts updated %0d, added %0d, stale %0d, full %0d; mismatches %0d",
                 verdict_hits[VERDICT_UPDATED], verdict_hits[VERDICT_ADDED],
                 verdict_hits[VERDICT_STALE], verdict_hits[VERDICT_FULL], mismatches);
        if (mismatches == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule

// File: files.f
hdl/psmg_pkg.sv
hdl/psmg_in_if.sv
hdl/psmg_res_if.sv
hdl/psmg_cell.sv
hdl/per_stream_monotonic_gate_top.sv
hdl/psmg_chk.sv
bench/tb_top.sv
